// ===== hdl/nnd_pkg.sv =====
// Shared types and constants for the nearest-neighbor downscaler.
// No dependencies; imported by every module of the block.
package nnd_pkg;

  // Largest source tile side; sets counter and accumulator widths.
  localparam int unsigned MAX_DIM = 256;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM);
  localparam int unsigned CMP_W   = DIM_W + 1;
  localparam int unsigned ACC_W   = 2 * DIM_W;

  // Fixed field widths of the registers and the stream words.
  localparam int unsigned SRC_W   = 9;
  localparam int unsigned DST_W   = 8;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned IDX_W   = 2;

  // Register reset values.
  localparam logic [SRC_W-1:0] SRC_WIDTH_RST  = SRC_W'(48);
  localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = SRC_W'(96);
  localparam logic [DST_W-1:0] DST_WIDTH_RST  = DST_W'(36);
  localparam logic [DST_W-1:0] DST_HEIGHT_RST = DST_W'(72);

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_e;

  // Effective (clamped) tile geometry.
  typedef struct packed {
    logic [SRC_W-1:0] w;
    logic [SRC_W-1:0] h;
    logic [DST_W-1:0] dw;
    logic [DST_W-1:0] dh;
  } dims_t;

  // Selection outcome for the word in the input stage.
  typedef struct packed {
    logic hit;
    logic row_end;
    logic tile_end;
  } sel_t;

endpackage

// ===== hdl/nnd_cfg.sv =====
// Configuration registers and size clamping for the downscaler.
// Depends on nnd_pkg.
module nnd_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [nnd_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [nnd_pkg::SRC_W-1:0]  cfg_data_i,
  output nnd_pkg::dims_t             dims_o
);
  import nnd_pkg::*;

  logic [SRC_W-1:0] src_w_q, src_h_q;
  logic [DST_W-1:0] dst_w_q, dst_h_q;
  logic [SRC_W-1:0] w_eff, h_eff, w_m1, h_m1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_WIDTH_RST;
      src_h_q <= SRC_HEIGHT_RST;
      dst_w_q <= DST_WIDTH_RST;
      dst_h_q <= DST_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SRC_WIDTH:  src_w_q <= cfg_data_i;
        CFG_SRC_HEIGHT: src_h_q <= cfg_data_i;
        CFG_DST_WIDTH:  dst_w_q <= cfg_data_i[DST_W-1:0];
        CFG_DST_HEIGHT: dst_h_q <= cfg_data_i[DST_W-1:0];
        default: ;
      endcase
    end
  end

  // Source sizes saturate into [2, MAX_DIM]
  always_comb begin
    if (src_w_q < SRC_W'(2))            w_eff = SRC_W'(2);
    else if (src_w_q > SRC_W'(MAX_DIM)) w_eff = SRC_W'(MAX_DIM);
    else                                w_eff = src_w_q;
    if (src_h_q < SRC_W'(2))            h_eff = SRC_W'(2);
    else if (src_h_q > SRC_W'(MAX_DIM)) h_eff = SRC_W'(MAX_DIM);
    else                                h_eff = src_h_q;
  end

  assign w_m1 = w_eff - SRC_W'(1);
  assign h_m1 = h_eff - SRC_W'(1);

  // Output sizes: zero reads as one, too large clamps to source minus one
  always_comb begin
    dims_o.w = w_eff;
    dims_o.h = h_eff;
    if (dst_w_q == '0)                      dims_o.dw = DST_W'(1);
    else if (SRC_W'(dst_w_q) > w_m1)        dims_o.dw = w_m1[DST_W-1:0];
    else                                    dims_o.dw = dst_w_q;
    if (dst_h_q == '0)                      dims_o.dh = DST_W'(1);
    else if (SRC_W'(dst_h_q) > h_m1)        dims_o.dh = h_m1[DST_W-1:0];
    else                                    dims_o.dh = dst_h_q;
  end

endmodule

// ===== hdl/nnd_select.sv =====
// Position counters and add-compare accumulators deciding which source
// word is kept. Depends on nnd_pkg.
module nnd_select (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nnd_pkg::dims_t dims_i,
  input  logic           adv_i,
  output nnd_pkg::sel_t  sel_o
);
  import nnd_pkg::*;

  logic [DIM_W-1:0] in_col_q, in_col_d, in_row_q, in_row_d;
  logic [DIM_W-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [ACC_W-1:0] col_in_acc_q, col_in_acc_d, col_out_acc_q, col_out_acc_d;
  logic [ACC_W-1:0] row_in_acc_q, row_in_acc_d, row_out_acc_q, row_out_acc_d;

  logic [ACC_W:0]   col_lim, row_lim;
  logic             col_hit, row_hit, row_open, last_col, last_row;
  logic             last_in_col, last_in_row;
  logic [ACC_W-1:0] w_m1, h_m1;

  assign w_m1 = ACC_W'(dims_i.w - SRC_W'(1));
  assign h_m1 = ACC_W'(dims_i.h - SRC_W'(1));

  // Hit tests: in_acc <= out_acc < in_acc + dst size
  assign col_lim  = {1'b0, col_in_acc_q} + (ACC_W+1)'(dims_i.dw);
  assign row_lim  = {1'b0, row_in_acc_q} + (ACC_W+1)'(dims_i.dh);
  assign col_hit  = (col_in_acc_q <= col_out_acc_q) && ({1'b0, col_out_acc_q} < col_lim);
  assign row_hit  = (row_in_acc_q <= row_out_acc_q) && ({1'b0, row_out_acc_q} < row_lim);
  assign row_open = CMP_W'(out_row_q) < CMP_W'(dims_i.dh);

  assign last_col    = (CMP_W'(out_col_q) + CMP_W'(1)) >= CMP_W'(dims_i.dw);
  assign last_row    = (CMP_W'(out_row_q) + CMP_W'(1)) >= CMP_W'(dims_i.dh);
  assign last_in_col = (CMP_W'(in_col_q) + CMP_W'(1)) >= CMP_W'(dims_i.w);
  assign last_in_row = (CMP_W'(in_row_q) + CMP_W'(1)) >= CMP_W'(dims_i.h);

  always_comb begin
    sel_o.hit      = col_hit && row_hit && row_open;
    sel_o.row_end  = last_col;
    sel_o.tile_end = last_col && last_row;
  end

  // Next state: output position first, then source position overrides
  always_comb begin
    in_col_d      = in_col_q;
    in_row_d      = in_row_q;
    out_col_d     = out_col_q;
    out_row_d     = out_row_q;
    col_in_acc_d  = col_in_acc_q;
    col_out_acc_d = col_out_acc_q;
    row_in_acc_d  = row_in_acc_q;
    row_out_acc_d = row_out_acc_q;

    if (sel_o.hit) begin
      if (last_col) begin
        out_col_d     = '0;
        col_out_acc_d = '0;
        out_row_d     = out_row_q + DIM_W'(1);
        row_out_acc_d = row_out_acc_q + h_m1;
      end else begin
        out_col_d     = out_col_q + DIM_W'(1);
        col_out_acc_d = col_out_acc_q + w_m1;
      end
    end

    if (last_in_col) begin
      in_col_d      = '0;
      col_in_acc_d  = '0;
      out_col_d     = '0;
      col_out_acc_d = '0;
      if (last_in_row) begin
        // tile done: start the next one from the origin
        in_row_d      = '0;
        out_row_d     = '0;
        row_in_acc_d  = '0;
        row_out_acc_d = '0;
      end else begin
        in_row_d     = in_row_q + DIM_W'(1);
        row_in_acc_d = row_in_acc_q + ACC_W'(dims_i.dh);
      end
    end else begin
      in_col_d     = in_col_q + DIM_W'(1);
      col_in_acc_d = col_in_acc_q + ACC_W'(dims_i.dw);
    end
  end

  // State registers advance once per consumed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q      <= '0;
      in_row_q      <= '0;
      out_col_q     <= '0;
      out_row_q     <= '0;
      col_in_acc_q  <= '0;
      col_out_acc_q <= '0;
      row_in_acc_q  <= '0;
      row_out_acc_q <= '0;
    end else if (adv_i) begin
      in_col_q      <= in_col_d;
      in_row_q      <= in_row_d;
      out_col_q     <= out_col_d;
      out_row_q     <= out_row_d;
      col_in_acc_q  <= col_in_acc_d;
      col_out_acc_q <= col_out_acc_d;
      row_in_acc_q  <= row_in_acc_d;
      row_out_acc_q <= row_out_acc_d;
    end
  end

endmodule

// ===== hdl/nearest_neighbor_downscaler.sv =====
// Top level of the nearest-neighbor downscaler: input register, selection
// and output register. Depends on nnd_pkg, nnd_cfg and nnd_select.
//
// Usage:
//   Source pixels enter on s_axis in raster order, one word per pixel.
//   Kept pixels leave on m_axis; tuser[0] marks the last pixel of an output
//   row and tlast the last pixel of the output tile. After the last source
//   pixel of a tile the counters clear and the next tile starts.
//   Sizes are written through cfg_we_i / cfg_idx_i / cfg_data_i (index 0
//   source width, 1 source height, 2 output width, 3 output height) while
//   the stream is idle; they take effect on the next word.
//   A kept pixel is registered in the input stage and then in the output
//   stage, which drives m_axis. Throughput: one word per cycle while no
//   kept word waits for a stalled m_axis, set by the single add-compare
//   pass between the two registers.
//   When m_axis stalls, the word in the input stage still moves on if it is
//   not kept; a kept word waits there and s_axis_tready drops only when
//   both stages are full.
//   Reset clears both stages, the counters and loads the default sizes
//   48 x 96 to 36 x 72.
module nearest_neighbor_downscaler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [nnd_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [nnd_pkg::SRC_W-1:0]  cfg_data_i,
  // source stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] pixel_in
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [7:0] pixel_out
  output logic                       m_axis_tlast,   // tile_end
  output logic [0:0]                 m_axis_tuser    // [0] row_end
);
  import nnd_pkg::*;

  dims_t            dims;
  sel_t             sel;
  logic             in_valid_q;
  logic [PIX_W-1:0] in_pix_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_row_end_q, out_tile_end_q;
  logic             out_free, adv, load_out;

  nnd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .dims_o     (dims)
  );

  nnd_select u_select (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dims_i (dims),
    .adv_i  (adv),
    .sel_o  (sel)
  );

  // Handshake: input stage drains unless a kept word meets a full output
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && (!sel.hit || out_free);
  assign load_out      = adv && sel.hit;
  assign s_axis_tready = !in_valid_q || adv;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_pix_q <= s_axis_tdata;
    end
  end

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pix_q      <= in_pix_q;
      out_row_end_q  <= sel.row_end;
      out_tile_end_q <= sel.tile_end;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_pix_q;
  assign m_axis_tlast    = out_tile_end_q;
  assign m_axis_tuser[0] = out_row_end_q;

endmodule
